>>> rtl/phpd_pkg.sv
`timescale 1ns / 1ps

package phpd_pkg;

	localparam int SAMPLE_W  = 14;
	localparam int AMP_W     = 18;
	localparam int IDX_W     = 10;
	localparam int DEPTH_W   = 14;
	localparam int SEP_W     = 10;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_VALLEY_DEPTH      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PILEUP_SEPARATION = 1'd1;

	localparam logic [DEPTH_W-1:0] VALLEY_DEPTH_RST      = 14'd50;
	localparam logic [SEP_W-1:0]   PILEUP_SEPARATION_RST = 10'd30;

	localparam logic [IDX_W-1:0] IDX_MAX = '1;

	localparam int PREGATE_DEF     = 25;
	localparam int LAG_DEF         = 6;
	localparam int MAX_SAMPLES_DEF = 1024;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} in_word_t;

	typedef struct packed {
		logic [AMP_W-1:0] amplitude;
		logic [IDX_W-1:0] min_index;
		logic             pileup;
		logic             trace_error;
	} out_word_t;

endpackage

>>> rtl/pulse_height_pileup_detector_top.sv
// Pulse height analyzer with pileup detection for negative-going traces. One ADC
// sample word is taken per clock (in_valid/in_stall), with last marking the end of
// a trace; the block keeps up with one sample every cycle and stalls its input only
// while a finished result sits in the output register with out_stall high. The
// first PREGATE samples form the baseline, the earliest minimum and its position are
// tracked, and valleys deeper than valley_depth against the samples LAG away on
// both sides are found; two valleys spaced more than pileup_separation apart set
// pileup. Each trace yields one result word via a registered state-update stage, a
// baseline-difference stage and a reciprocal multiply for the division by PREGATE.
// trace_error marks traces shorter than PREGATE (amplitude then reads 0) or longer
// than MAX_SAMPLES (index saturates). Registers are written via cfg_we, cfg_index
// and cfg_data by the user only while no trace is active; unenforced by the block.
`timescale 1ns / 1ps

module pulse_height_pileup_detector_top #(
	parameter int PREGATE     = phpd_pkg::PREGATE_DEF,
	parameter int LAG         = phpd_pkg::LAG_DEF,
	parameter int MAX_SAMPLES = phpd_pkg::MAX_SAMPLES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  phpd_pkg::in_word_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output phpd_pkg::out_word_t          out_data,
	input  logic                         cfg_we,
	input  logic [phpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [phpd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import phpd_pkg::*;

	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int NXW  = CW + 9;
	localparam int PW   = $clog2(MAX_SAMPLES);
	localparam int DW   = (PW > SEP_W) ? PW : SEP_W;
	localparam int BW   = SAMPLE_W + $clog2(PREGATE + 1);
	localparam int XW   = SAMPLE_W + 4 + $clog2(PREGATE);
	localparam int AMP_SHIFT = XW + $clog2(PREGATE);
	localparam int MW   = XW + 2;
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << AMP_SHIFT) + 64'(PREGATE) - 64'd1) / 64'(PREGATE);
	localparam logic [MW-1:0] RECIP = RECIP_WIDE[MW-1:0];
	localparam int WIN = 2 * LAG;

	// configuration
	logic [DEPTH_W-1:0] depth_q;
	logic [SEP_W-1:0]   sep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= VALLEY_DEPTH_RST;
			sep_q   <= PILEUP_SEPARATION_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VALLEY_DEPTH:      depth_q <= cfg_data[DEPTH_W-1:0];
				REG_PILEUP_SEPARATION: sep_q   <= cfg_data[SEP_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic en;
	logic acc;
	logic out_valid_q;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;
	assign acc      = in_valid && en;

	// per-trace state
	logic [SAMPLE_W-1:0] win_q [WIN];
	logic [CW-1:0]       cnt_q;
	logic [BW-1:0]       base_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [IDX_W-1:0]    minpos_q;
	logic [PW-1:0]       lastv_q;
	logic                seen_q;
	logic                pile_q;

	logic [SAMPLE_W-1:0] s;
	logic [NXW-1:0]      n_ext;
	logic                in_range;
	logic [BW-1:0]       base_nx;
	logic [SAMPLE_W-1:0] min_nx;
	logic [IDX_W-1:0]    minpos_nx;
	logic                take_min;
	logic [IDX_W-1:0]    pos_sat;
	logic [SAMPLE_W:0]   thr;
	logic                valley;
	logic [PW-1:0]       pos;
	logic [DW-1:0]       gap;
	logic                pile_nx;
	logic [PW-1:0]       lastv_nx;
	logic                seen_nx;
	logic [CW-1:0]       cnt_nx;
	logic                len_short;

	always_comb begin
		s        = in_data.sample;
		n_ext    = NXW'(cnt_q);
		in_range = n_ext < NXW'(MAX_SAMPLES);

		base_nx = (n_ext < NXW'(PREGATE)) ? base_q + BW'(s) : base_q;

		take_min  = (s < min_q) || (cnt_q == '0);
		pos_sat   = (n_ext > NXW'(IDX_MAX)) ? IDX_MAX : n_ext[IDX_W-1:0];
		min_nx    = take_min ? s : min_q;
		minpos_nx = take_min ? pos_sat : minpos_q;

		// left neighbor, center and right neighbor after the window shift
		thr    = {1'b0, win_q[LAG-1]} + {1'b0, depth_q};
		valley = in_range && (n_ext >= NXW'(WIN)) &&
			({1'b0, win_q[WIN-1]} > thr) && ({1'b0, s} > thr);

		pos      = PW'(cnt_q - CW'(LAG));
		gap      = DW'(pos - lastv_q);
		pile_nx  = pile_q || (valley && seen_q && (gap > DW'(sep_q)));
		lastv_nx = valley ? pos : lastv_q;
		seen_nx  = seen_q || valley;

		cnt_nx    = in_range ? cnt_q + CW'(1) : cnt_q;
		len_short = n_ext < NXW'(PREGATE - 1);
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			win_q[0] <= s;
			for (int k = 1; k < WIN; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			base_q   <= '0;
			min_q    <= '1;
			minpos_q <= '0;
			lastv_q  <= '0;
			seen_q   <= 1'b0;
			pile_q   <= 1'b0;
		end else if (acc) begin
			if (in_data.last) begin
				cnt_q    <= '0;
				base_q   <= '0;
				min_q    <= '1;
				minpos_q <= '0;
				lastv_q  <= '0;
				seen_q   <= 1'b0;
				pile_q   <= 1'b0;
			end else begin
				cnt_q    <= cnt_nx;
				base_q   <= base_nx;
				min_q    <= min_nx;
				minpos_q <= minpos_nx;
				lastv_q  <= lastv_nx;
				seen_q   <= seen_nx;
				pile_q   <= pile_nx;
			end
		end
	end

	// result pipeline
	logic                s1_valid, s2_valid;
	logic [BW-1:0]       sum_s1;
	logic [SAMPLE_W-1:0] min_s1;
	logic [IDX_W-1:0]    idx_s1, idx_s2;
	logic                pile_s1, pile_s2;
	logic                short_s1, short_s2;
	logic                err_s1, err_s2;
	logic [XW-1:0]       x_s2;
	logic [BW-1:0]       diff;
	logic [XW+MW-1:0]    prod;
	out_word_t           out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			s1_valid    <= acc && in_data.last;
			s2_valid    <= s1_valid;
			out_valid_q <= s2_valid;
		end
	end

	// every baseline sample is at or above the minimum, so diff cannot go negative unless the trace is short
	assign diff = sum_s1 - BW'(PREGATE) * BW'(min_s1);
	assign prod = (XW + MW)'(x_s2) * (XW + MW)'(RECIP);

	always_ff @(posedge clk) begin
		if (acc && in_data.last) begin
			sum_s1   <= base_nx;
			min_s1   <= min_nx;
			idx_s1   <= minpos_nx;
			pile_s1  <= pile_nx;
			short_s1 <= len_short;
			err_s1   <= len_short || !in_range;
		end
		if (en && s1_valid) begin
			x_s2     <= (XW'(diff) << 4) + XW'(PREGATE / 2);
			idx_s2   <= idx_s1;
			pile_s2  <= pile_s1;
			short_s2 <= short_s1;
			err_s2   <= err_s1;
		end
		if (en && s2_valid) begin
			out_q.amplitude   <= short_s2 ? '0 : prod[AMP_SHIFT +: AMP_W];
			out_q.min_index   <= idx_s2;
			out_q.pileup      <= pile_s2;
			out_q.trace_error <= err_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> sim/pulse_height_checker.sv
`timescale 1ns / 1ps

module pulse_height_checker #(
	parameter int PREGATE     = phpd_pkg::PREGATE_DEF,
	parameter int LAG         = phpd_pkg::LAG_DEF,
	parameter int MAX_SAMPLES = phpd_pkg::MAX_SAMPLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  phpd_pkg::in_word_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  phpd_pkg::out_word_t             out_data,
	input  logic                            cfg_we,
	input  logic [phpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [phpd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending
);

	import phpd_pkg::*;

	localparam int WIN = 2 * LAG + 1;

	logic [DEPTH_W-1:0]  depth_thr;
	logic [SEP_W-1:0]    sep_thr;
	logic [SAMPLE_W-1:0] window [WIN];
	logic [18:0]         base_sum;
	logic [SAMPLE_W-1:0] min_val;
	logic [IDX_W-1:0]    min_pos;
	int unsigned         taken;
	int unsigned         valley_pos;
	bit                  valley_found;
	bit                  pile;
	out_word_t           expected_pulses[$];

	task automatic start_trace();
		for (int k = 0; k < WIN; k++)
			window[k] = '0;
		base_sum     = '0;
		min_val      = '1;
		min_pos      = '0;
		taken        = 0;
		valley_pos   = 0;
		valley_found = 1'b0;
		pile         = 1'b0;
	endtask

	// folds one sample word into the trace state; on last, queues the pulse result
	task automatic fold_sample(input in_word_t w);
		int unsigned         n;
		int unsigned         pos;
		bit                  in_range;
		bit                  too_short;
		logic [SAMPLE_W-1:0] c;
		logic [SAMPLE_W-1:0] l;
		logic [SAMPLE_W-1:0] r;
		longint              diff;
		longint              amp;
		out_word_t           res;

		n = taken;
		in_range = n < MAX_SAMPLES;
		for (int k = WIN - 1; k > 0; k--)
			window[k] = window[k-1];
		window[0] = w.sample;

		if (n < PREGATE)
			base_sum += w.sample;

		if (w.sample < min_val || n == 0) begin
			min_val = w.sample;
			min_pos = (n > IDX_MAX) ? IDX_MAX : IDX_W'(n);
		end

		// center is tested once the sample LAG after it has arrived
		if (in_range && n >= 2 * LAG) begin
			c = window[LAG];
			l = window[2*LAG];
			r = window[0];
			if (l > c && r > c && (l - c) > depth_thr && (r - c) > depth_thr) begin
				pos = n - LAG;
				if (valley_found && (pos - valley_pos) > sep_thr)
					pile = 1'b1;
				valley_pos   = pos;
				valley_found = 1'b1;
			end
		end

		if (in_range)
			taken = n + 1;

		if (w.last) begin
			too_short = (n + 1) < PREGATE;
			amp = 0;
			if (!too_short) begin
				diff = longint'(base_sum) - longint'(PREGATE) * longint'(min_val);
				amp  = (16 * diff + PREGATE / 2) / PREGATE;
				if (amp > 262143)
					amp = 262143;
			end
			res.amplitude   = AMP_W'(amp);
			res.min_index   = min_pos;
			res.pileup      = pile;
			res.trace_error = too_short || !in_range;
			expected_pulses = {expected_pulses, res};
			start_trace();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;

		if (!arst_n) begin
			depth_thr  = VALLEY_DEPTH_RST;
			sep_thr    = PILEUP_SEPARATION_RST;
			fail_count = 0;
			expected_pulses.delete();
			start_trace();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VALLEY_DEPTH:      depth_thr = cfg_data[DEPTH_W-1:0];
					REG_PILEUP_SEPARATION: sep_thr   = cfg_data[SEP_W-1:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				if (expected_pulses.size() == 0) begin
					$error("result word %h with nothing expected", out_data);
					fail_count++;
				end else begin
					want = expected_pulses.pop_front();
					check_field("amplitude", want.amplitude, out_data.amplitude);
					check_field("min_index", want.min_index, out_data.min_index);
					check_field("pileup", want.pileup, out_data.pileup);
					check_field("trace_error", want.trace_error, out_data.trace_error);
				end
			end

			if (in_valid && !in_stall)
				fold_sample(in_data);
		end
		pending = expected_pulses.size();
	end

endmodule

>>> sim/pulse_height_pileup_detector_top_tb.sv
`timescale 1ns / 1ps

module pulse_height_pileup_detector_top_tb;

	import phpd_pkg::*;

	localparam int HANG_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_word_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_word_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int quiet_cycles;
	bit calm;
	bit hold_go;

	pulse_height_pileup_detector_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pulse_height_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hang detection: nothing moving on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == HANG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off when requested
	initial begin
		int hold_left;
		bit hold_used;

		hold_left = 0;
		hold_used = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (calm)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < 31);
		end
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic l);
		while (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{sample: s, last: l};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// negative-going trace: baseline with noise and up to three triangular dips, or random junk
	task automatic send_trace(input int len, input bit tail_dip);
		int level;
		int noise;
		int dips;
		int width;
		int depth;
		int ctr [3];
		int v;
		int d;
		bit junk;

		junk  = ($urandom_range(9) == 0);
		level = ($urandom_range(3) == 0) ? int'($urandom_range(16383))
			: int'($urandom_range(15000, 4000));
		noise = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(40));
		dips  = $urandom_range(3);
		width = $urandom_range(10, 2);
		depth = $urandom_range(level);
		for (int k = 0; k < 3; k++)
			ctr[k] = $urandom_range(len - 1);
		if (tail_dip) begin
			dips   = 1;
			ctr[0] = len - 3;
			depth  = level;
		end
		for (int pos = 0; pos < len; pos++) begin
			v = level + int'($urandom_range(2 * noise)) - noise;
			for (int k = 0; k < dips; k++) begin
				d = (pos > ctr[k]) ? pos - ctr[k] : ctr[k] - pos;
				if (d < width)
					v -= depth * (width - d) / width;
			end
			if (v < 0)
				v = 0;
			if (v > 16383)
				v = 16383;
			if (junk)
				v = $urandom_range(16383);
			send_word(SAMPLE_W'(v), pos == len - 1);
		end
	endtask

	task automatic run_traces(input int budget);
		int spent;
		int len;

		spent = 0;
		while (spent < budget) begin
			case ($urandom_range(9))
				0:       len = $urandom_range(PREGATE_DEF - 1, 1);
				1:       len = $urandom_range(300, 90);
				default: len = $urandom_range(90, PREGATE_DEF);
			endcase
			send_trace(len, 1'b0);
			spent += len;
		end
	endtask

	// drain, then give the pipeline time to finish before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [SAMPLE_W-1:0] v;

		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_VALLEY_DEPTH;
		cfg_data  = '0;
		calm      = 1'b0;
		hold_go   = 1'b0;
		arst_n    = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// one-word traces at both sample extremes (short, amplitude zero)
		send_word('1, 1'b1);
		send_word('0, 1'b1);
		// trace of exactly PREGATE words, valleys at 6 and 18, full-scale word at the end
		for (int i = 0; i < PREGATE_DEF; i++) begin
			v = 14'd1000;
			if (i == 6)
				v = 14'd0;
			else if (i == 18)
				v = 14'd500;
			else if (i == PREGATE_DEF - 1)
				v = '1;
			send_word(v, i == PREGATE_DEF - 1);
		end
		settle();

		write_reg(REG_VALLEY_DEPTH, '0);
		write_reg(REG_PILEUP_SEPARATION, '0);
		calm <= 1'b1;
		run_traces(200);
		calm <= 1'b0;
		settle();

		write_reg(REG_VALLEY_DEPTH, 14'd16383);
		write_reg(REG_PILEUP_SEPARATION, 14'd1023);
		run_traces(170);
		settle();

		// overlong trace with a deep dip near its end, close to or past the index range
		write_reg(REG_VALLEY_DEPTH, 14'd20);
		write_reg(REG_PILEUP_SEPARATION, 14'd5);
		send_trace(1025 + int'($urandom_range(6)), 1'b1);
		hold_go <= 1'b1;
		repeat (40) send_trace($urandom_range(4, 1), 1'b0);
		run_traces(100);
		settle();

		// upper data bits are don't-care for the separation register
		write_reg(REG_VALLEY_DEPTH, CFG_DATA_W'($urandom_range(400)));
		write_reg(REG_PILEUP_SEPARATION, CFG_DATA_W'($urandom_range(16383)));
		run_traces(170);
		settle();

		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
